### src/stereo_soft_clip_lowpass_core_defines.svh
// Assertion macros used by the checker file.
`ifndef STEREO_SOFT_CLIP_LOWPASS_CORE_DEFINES_SVH
`define STEREO_SOFT_CLIP_LOWPASS_CORE_DEFINES_SVH

// Checked on every clock edge outside reset.
`define SCSLP_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SCSLP_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

### src/scslp_pkg.sv
package scslp_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int FRAC        = SAMPLE_BITS - 1;
  localparam int EXTRA       = 3;
  localparam int Z_W         = SAMPLE_BITS + 4;
  localparam int X_W         = SAMPLE_BITS + 5;
  localparam int S1_W        = SAMPLE_BITS + 1;
  localparam int DEN_W       = X_W;
  localparam int Q_W         = SAMPLE_BITS;
  localparam int NUM_W       = 2 * SAMPLE_BITS - 1;
  localparam int CNT_W       = $clog2(Q_W + 1);
  localparam int A_W         = Z_W + 1;
  localparam int B_W         = 18;
  localparam int PROD_W      = A_W + B_W;
  localparam int GAIN_SH     = 11;
  localparam int MIX_SH      = 16;
  localparam int OUT_SH      = 12 + EXTRA;

  localparam longint unsigned ONE_L = 64'd1 << FRAC;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam logic [16:0] UNITY = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRE_GAIN  = 3'd0,
    REG_GRIT_MIX  = 3'd1,
    REG_WET_MIX   = 3'd2,
    REG_LPF_ALPHA = 3'd3,
    REG_OUT_GAIN  = 3'd4
  } cfg_idx_e;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]      prod_t;

  typedef struct packed {
    logic [15:0] pre_gain;
    logic [16:0] grit_mix;
    logic [16:0] wet_mix;
    logic [16:0] lpf_alpha;
    logic [14:0] out_gain;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic done;
  } lane_stat_t;

  function automatic logic [16:0] sat_weight(logic [16:0] v);
    return (v > UNITY) ? UNITY : v;
  endfunction

  // Rounds to nearest with ties towards plus infinity.
  function automatic prod_t rnd_shift(prod_t t, int unsigned s);
    prod_t half;
    half = PROD_W'(1) << (s - 1);
    return (t + half) >>> s;
  endfunction

endpackage

### src/scslp_if.sv
interface scslp_in_if import scslp_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t left_in;
  sample_t right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface scslp_out_if import scslp_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t left_out;
  sample_t right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink (input valid, input left_out, input right_out, output ready);
endinterface

interface scslp_cfg_if import scslp_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### src/stereo_soft_clip_lowpass_core.sv
// Stereo soft-clip saturator with a one-pole lowpass and output gain.
// The frame channel takes one word holding a left and a right Q1.23 sample;
// the result channel gives one processed word for every frame word taken.
// Both channels move a word on a clock edge where valid and ready are high.
// The configuration channel is always ready and writes the register whose
// index it carries: pre-gain, grit mix, wet mix, lowpass alpha, output gain.
// Registers should only be written while no frame is in progress.
// Two identical lanes, one for each side, each run their own multiplier
// and bit-serial divider; the divider computes the soft clip.
// The result word is loaded into the output register when both lanes are
// done, and a new frame word is taken once both lanes have handed on their
// results, so the lanes work on one frame at a time.
// When the receiver stalls, the finished word waits in the output register
// and the lanes hold their next result; frame ready stays low meanwhile.
// Reset clears both filter states, restores the register defaults and
// empties the output register.
module stereo_soft_clip_lowpass_core import scslp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  scslp_in_if.sink    frame,
  scslp_out_if.source result,
  scslp_cfg_if.sink   cfg
);

  cfg_t       regs;
  lane_stat_t stat_l;
  lane_stat_t stat_r;
  sample_t    res_l;
  sample_t    res_r;
  logic       take;
  logic       start;

  assign cfg.ready   = 1'b1;
  assign frame.ready = stat_l.idle & stat_r.idle;
  assign start       = frame.valid & frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pre_gain  <= 16'd21504;
      regs.grit_mix  <= 17'd0;
      regs.wet_mix   <= 17'd32768;
      regs.lpf_alpha <= 17'd43000;
      regs.out_gain  <= 15'd4096;
    end else if (cfg.valid) begin
      case (cfg_idx_e'(cfg.index))
        REG_PRE_GAIN:  regs.pre_gain  <= cfg.data[15:0];
        REG_GRIT_MIX:  regs.grit_mix  <= sat_weight(cfg.data);
        REG_WET_MIX:   regs.wet_mix   <= sat_weight(cfg.data);
        REG_LPF_ALPHA: regs.lpf_alpha <= sat_weight(cfg.data);
        REG_OUT_GAIN:  regs.out_gain  <= cfg.data[14:0];
        default: begin
        end
      endcase
    end
  end

  scslp_lane u_lane_l (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .take   (take),
    .dry_in (frame.left_in),
    .cfg    (regs),
    .stat   (stat_l),
    .res    (res_l)
  );

  scslp_lane u_lane_r (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .take   (take),
    .dry_in (frame.right_in),
    .cfg    (regs),
    .stat   (stat_r),
    .res    (res_r)
  );

  scslp_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .stat_l (stat_l),
    .stat_r (stat_r),
    .res_l  (res_l),
    .res_r  (res_r),
    .take   (take),
    .result (result)
  );

endmodule

### src/scslp_div.sv
module scslp_div import scslp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DEN_W-1:0] den_in,
  output logic             done,
  output logic [Q_W-1:0]   quo
);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [Q_W-1:0]   nlo;
  logic [NUM_W-1:0] num;
  logic [DEN_W:0]   rem2;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign num  = (NUM_W'(1) << (2 * FRAC)) + NUM_W'(den_in >> 1);
  assign rem2 = {rem, nlo[Q_W-1]};
  assign diff = rem2 - {1'b0, den};
  assign ge   = (rem2 >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(Q_W);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den <= den_in;
      rem <= DEN_W'(num[NUM_W-1:Q_W]);
      nlo <= num[Q_W-1:0];
    end else if (running) begin
      rem <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
      nlo <= nlo << 1;
      quo <= {quo[Q_W-2:0], ge};
    end
  end

endmodule

### src/scslp_lane.sv
module scslp_lane import scslp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       take,
  input  sample_t    dry_in,
  input  cfg_t       cfg,
  output lane_stat_t stat,
  output sample_t    res
);

  typedef enum logic [12:0] {
    L_IDLE     = 13'b0000000000001,
    L_GAIN_MUL = 13'b0000000000010,
    L_GAIN_RND = 13'b0000000000100,
    L_DIV      = 13'b0000000001000,
    L_GRIT_MUL = 13'b0000000010000,
    L_GRIT_ADD = 13'b0000000100000,
    L_WET_MUL  = 13'b0000001000000,
    L_WET_ADD  = 13'b0000010000000,
    L_LPF_MUL  = 13'b0000100000000,
    L_LPF_ADD  = 13'b0001000000000,
    L_OUT_MUL  = 13'b0010000000000,
    L_OUT_SAT  = 13'b0100000000000,
    L_DONE     = 13'b1000000000000
  } lane_state_t;

  localparam logic signed [X_W-1:0]   H_MAX  = X_W'(ONE_L);
  localparam logic signed [X_W-1:0]   H_MIN  = -H_MAX;
  localparam logic signed [Z_W+1:0]   ZS_MAX = {3'b000, {(Z_W-1){1'b1}}};
  localparam logic signed [Z_W+1:0]   ZS_MIN = {3'b111, {(Z_W-1){1'b0}}};
  localparam logic signed [PROD_W-1:0] O_MAX =
    {{(PROD_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] O_MIN =
    {{(PROD_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  lane_state_t state, state_next;

  sample_t                 dry;
  prod_t                   prod;
  logic                    xneg;
  logic signed [S1_W-1:0]  hard;
  logic signed [S1_W-1:0]  soft_val;
  logic signed [S1_W-1:0]  clipped;
  logic signed [S1_W-1:0]  y;
  logic signed [Z_W-1:0]   z;

  logic signed [A_W-1:0]   mul_a;
  logic [16:0]             mul_b;
  prod_t                   r_gain;
  prod_t                   r_mix;
  prod_t                   r_out;
  logic signed [X_W-1:0]   x_w;
  logic [X_W-1:0]          mag;
  logic [DEN_W-1:0]        den;
  logic signed [S1_W-1:0]  softm;
  logic signed [Z_W-1:0]   yz;
  logic signed [Z_W+1:0]   zsum;
  logic                    div_done;
  logic [Q_W-1:0]          div_quo;
  logic                    div_start;

  assign r_gain    = rnd_shift(prod, GAIN_SH);
  assign r_mix     = rnd_shift(prod, MIX_SH);
  assign r_out     = rnd_shift(prod, OUT_SH);
  assign x_w       = r_gain[X_W-1:0];
  assign mag       = x_w[X_W-1] ? $unsigned(-x_w) : $unsigned(x_w);
  assign den       = DEN_W'(ONE_L) + mag;
  assign softm     = S1_W'(ONE_L) - $signed({1'b0, div_quo});
  assign yz        = Z_W'(y) <<< EXTRA;
  assign zsum      = (Z_W+2)'(z) + r_mix[Z_W+1:0];
  assign div_start = (state == L_GAIN_RND);

  scslp_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .den_in (den),
    .done   (div_done),
    .quo    (div_quo)
  );

  always_comb begin
    mul_a = A_W'(dry);
    mul_b = {1'b0, cfg.pre_gain};
    case (state)
      L_GRIT_MUL: begin
        mul_a = A_W'(hard) - A_W'(soft_val);
        mul_b = cfg.grit_mix;
      end
      L_WET_MUL: begin
        mul_a = A_W'(clipped) - A_W'(dry);
        mul_b = cfg.wet_mix;
      end
      L_LPF_MUL: begin
        mul_a = A_W'(yz) - A_W'(z);
        mul_b = cfg.lpf_alpha;
      end
      L_OUT_MUL: begin
        mul_a = A_W'(z);
        mul_b = {2'b00, cfg.out_gain};
      end
      default: begin
        mul_a = A_W'(dry);
        mul_b = {1'b0, cfg.pre_gain};
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      L_IDLE:     if (start) state_next = L_GAIN_MUL;
      L_GAIN_MUL: state_next = L_GAIN_RND;
      L_GAIN_RND: state_next = L_DIV;
      L_DIV:      if (div_done) state_next = L_GRIT_MUL;
      L_GRIT_MUL: state_next = L_GRIT_ADD;
      L_GRIT_ADD: state_next = L_WET_MUL;
      L_WET_MUL:  state_next = L_WET_ADD;
      L_WET_ADD:  state_next = L_LPF_MUL;
      L_LPF_MUL:  state_next = L_LPF_ADD;
      L_LPF_ADD:  state_next = L_OUT_MUL;
      L_OUT_MUL:  state_next = L_OUT_SAT;
      L_OUT_SAT:  state_next = L_DONE;
      L_DONE:     if (take) state_next = L_IDLE;
      default:    state_next = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      z     <= '0;
    end else begin
      state <= state_next;
      if (state == L_LPF_ADD) begin
        if (zsum > ZS_MAX) begin
          z <= ZS_MAX[Z_W-1:0];
        end else if (zsum < ZS_MIN) begin
          z <= ZS_MIN[Z_W-1:0];
        end else begin
          z <= zsum[Z_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      L_IDLE: begin
        if (start) dry <= dry_in;
      end
      L_GAIN_MUL, L_GRIT_MUL, L_WET_MUL, L_LPF_MUL, L_OUT_MUL: begin
        prod <= mul_a * $signed({1'b0, mul_b});
      end
      L_GAIN_RND: begin
        xneg <= x_w[X_W-1];
        if (x_w > H_MAX) begin
          hard <= H_MAX[S1_W-1:0];
        end else if (x_w < H_MIN) begin
          hard <= H_MIN[S1_W-1:0];
        end else begin
          hard <= x_w[S1_W-1:0];
        end
      end
      L_DIV: begin
        if (div_done) soft_val <= xneg ? -softm : softm;
      end
      L_GRIT_ADD: begin
        clipped <= soft_val + r_mix[S1_W-1:0];
      end
      L_WET_ADD: begin
        y <= S1_W'(dry) + r_mix[S1_W-1:0];
      end
      L_OUT_SAT: begin
        if (r_out > O_MAX) begin
          res <= O_MAX[SAMPLE_BITS-1:0];
        end else if (r_out < O_MIN) begin
          res <= O_MIN[SAMPLE_BITS-1:0];
        end else begin
          res <= r_out[SAMPLE_BITS-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.idle = (state == L_IDLE);
  assign stat.done = (state == L_DONE);

endmodule

### src/scslp_merge.sv
module scslp_merge import scslp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  lane_stat_t  stat_l,
  input  lane_stat_t  stat_r,
  input  sample_t     res_l,
  input  sample_t     res_r,
  output logic        take,
  scslp_out_if.source result
);

  logic    valid;
  sample_t left;
  sample_t right;

  assign take = stat_l.done & stat_r.done & (~valid | result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      left  <= res_l;
      right <= res_r;
    end
  end

  assign result.valid     = valid;
  assign result.left_out  = left;
  assign result.right_out = right;

endmodule

### src/scslp_checker.sv
`include "stereo_soft_clip_lowpass_core_defines.svh"

module scslp_checker import scslp_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input sample_t left_out,
  input sample_t right_out
);

  logic in_acc;

  assign in_acc = in_valid & in_ready;

  `SCSLP_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !out_valid, "output word present after reset")
  `SCSLP_ASSERT(a_busy, clk, rst, in_acc |=> !in_ready, "frame taken while lanes busy")
  `SCSLP_ASSERT(a_no_early, clk, rst, in_acc |=> !$rose(out_valid), "result without latency")
  `SCSLP_ASSERT(a_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out), "stalled word changed")

endmodule

bind stereo_soft_clip_lowpass_core scslp_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (frame.valid),
  .in_ready  (frame.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .left_out  (result.left_out),
  .right_out (result.right_out)
);
